// ===== rtl/shell_sort_keyed_records_top_macros.svh =====
// Assertion helpers shared by the modules of the sorter.
// Both expect ports named clock and reset in the module that uses them.
`ifndef SHELL_SORT_KEYED_RECORDS_TOP_MACROS_SVH
`define SHELL_SORT_KEYED_RECORDS_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSK_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSK_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ssk_pkg.sv =====
`timescale 1ns / 1ps

package ssk_pkg;

   localparam int DEPTH_DEF    = 64;
   localparam int KEY_BITS_DEF = 16;
   localparam int TAG_BITS_DEF = 16;

   localparam int NUM_GAPS  = 9;
   localparam int GAP_IDX_W = 4;

   // Datapath operations, one per microcode step.
   typedef enum logic [3:0] {
      OP_LOAD,
      OP_GAP_INIT,
      OP_RD_I,
      OP_TAKE_I,
      OP_RD_X,
      OP_MOVE,
      OP_PLACE,
      OP_NEXT_GAP,
      OP_EMIT_INIT,
      OP_RD_E,
      OP_PUSH,
      OP_CLEAR
   } op_type;

   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_REQ,
      HOLD_RSP
   } hold_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NOT_LAST,
      COND_I_GE_N,
      COND_X_LT_GAP,
      COND_KEY_LESS,
      COND_GI_NONZERO,
      COND_E_DONE
   } cond_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_GAP_INIT,
      ST_OUTER,
      ST_TAKE,
      ST_CHECK,
      ST_COMPARE,
      ST_PLACE,
      ST_NEXT_GAP,
      ST_EMIT_INIT,
      ST_READ_E,
      ST_PUSH,
      ST_CLEAR
   } step_type;

   typedef struct packed {
      op_type   op;
      hold_type hold;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } dp_ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic req_last;
      logic rsp_free;
      logic i_ge_n;
      logic x_lt_gap;
      logic key_less;
      logic gi_nonzero;
      logic e_done;
   } dp_flags_type;

   function automatic int gap_at(input logic [GAP_IDX_W-1:0] idx);
      int g;
      unique case (idx)
         4'd0:    g = 1;
         4'd1:    g = 4;
         4'd2:    g = 10;
         4'd3:    g = 23;
         4'd4:    g = 57;
         4'd5:    g = 132;
         4'd6:    g = 301;
         4'd7:    g = 701;
         4'd8:    g = 1750;
         default: g = 1;
      endcase
      return g;
   endfunction

   // Index of the largest gap that does not exceed the record count, or of the smallest gap when none does.
   function automatic logic [GAP_IDX_W-1:0] first_gap_idx(input int n);
      logic [GAP_IDX_W-1:0] r;
      r = '0;
      for (int g = 1; g < NUM_GAPS; g++) begin
         if (gap_at(GAP_IDX_W'(g)) <= n) begin
            r = GAP_IDX_W'(g);
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/ssk_stream_if.sv =====
`timescale 1ns / 1ps

interface ssk_req_if
   import ssk_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] sort_key;
   logic [TAG_BITS-1:0] record_tag;
   logic                last_item;

   modport source (output valid, output sort_key, output record_tag, output last_item,
                   input ready);
   modport sink (input valid, input sort_key, input record_tag, input last_item,
                 output ready);
endinterface

interface ssk_rsp_if
   import ssk_pkg::*;
#(
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) ();
   logic                valid;
   logic                ready;
   logic [KEY_BITS-1:0] out_key;
   logic [TAG_BITS-1:0] out_tag;
   logic                out_last;
   logic                overflow;

   modport source (output valid, output out_key, output out_tag, output out_last,
                   output overflow, input ready);
   modport sink (input valid, input out_key, input out_tag, input out_last,
                 input overflow, output ready);
endinterface

// ===== rtl/shell_sort_keyed_records_top.sv =====
`timescale 1ns / 1ps
// Shell sorter for keyed records.
// Input words on req_if carry a key, a tag and last_item; result words on
// rsp_if carry the records in ascending key order, out_last on the final
// one and overflow on every word of a set that dropped records.
// Loading takes one cycle per word. Up to DEPTH records are stored; words
// that arrive when the store is full are dropped and flagged. The word with
// last_item ends the set and starts the sort; req_if.ready stays low until
// the whole set has been handed out.
// The sort runs as a microcoded program over one record store with one
// write and one registered read port: a setup step picks the first gap,
// each record is read, taken, checked and compared against the record one
// gap back and placed, and a next-gap step closes each gap pass. Output
// then reads and pushes each word, after an init step and before a final
// read and a clear step; a stalled receiver holds the program in its push
// step and the word in the output register.
// The next set may be loaded while the final result word still waits.
// Reset (synchronous, active high) empties the store and drops any pending
// result word.

module shell_sort_keyed_records_top
   import ssk_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   ssk_req_if.sink   req_if,
   ssk_rsp_if.source rsp_if
);

   dp_ctrl_type  dp_ctrl;
   dp_flags_type dp_flags;

   ssk_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (dp_flags),
      .ctrl  (dp_ctrl)
   );

   ssk_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .ctrl   (dp_ctrl),
      .flags  (dp_flags)
   );

endmodule

// ===== rtl/ssk_sequencer.sv =====
`timescale 1ns / 1ps
`include "shell_sort_keyed_records_top_macros.svh"

module ssk_sequencer
   import ssk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dp_flags_type flags,
   output dp_ctrl_type  ctrl
);

   step_type      step_ff;
   step_type      step_in;
   ctrl_word_type cw;
   logic          go;
   logic          cond_hit;

   // Control store. A step that is not held falls through to the next one
   // unless its jump condition is true.
   always_comb begin
      unique case (step_ff)
         ST_LOAD:      cw = '{OP_LOAD,      HOLD_REQ,  COND_NOT_LAST,   ST_LOAD};
         ST_GAP_INIT:  cw = '{OP_GAP_INIT,  HOLD_NONE, COND_NONE,       ST_LOAD};
         ST_OUTER:     cw = '{OP_RD_I,      HOLD_NONE, COND_I_GE_N,     ST_NEXT_GAP};
         ST_TAKE:      cw = '{OP_TAKE_I,    HOLD_NONE, COND_NONE,       ST_LOAD};
         ST_CHECK:     cw = '{OP_RD_X,      HOLD_NONE, COND_X_LT_GAP,   ST_PLACE};
         ST_COMPARE:   cw = '{OP_MOVE,      HOLD_NONE, COND_KEY_LESS,   ST_CHECK};
         ST_PLACE:     cw = '{OP_PLACE,     HOLD_NONE, COND_ALWAYS,     ST_OUTER};
         ST_NEXT_GAP:  cw = '{OP_NEXT_GAP,  HOLD_NONE, COND_GI_NONZERO, ST_OUTER};
         ST_EMIT_INIT: cw = '{OP_EMIT_INIT, HOLD_NONE, COND_NONE,       ST_LOAD};
         ST_READ_E:    cw = '{OP_RD_E,      HOLD_NONE, COND_E_DONE,     ST_CLEAR};
         ST_PUSH:      cw = '{OP_PUSH,      HOLD_RSP,  COND_ALWAYS,     ST_READ_E};
         ST_CLEAR:     cw = '{OP_CLEAR,     HOLD_NONE, COND_ALWAYS,     ST_LOAD};
         default:      cw = '{OP_CLEAR,     HOLD_NONE, COND_ALWAYS,     ST_LOAD};
      endcase
   end

   always_comb begin
      unique case (cw.hold)
         HOLD_NONE: go = 1'b1;
         HOLD_REQ:  go = flags.req_valid;
         HOLD_RSP:  go = flags.rsp_free;
         default:   go = 1'b0;
      endcase
   end

   always_comb begin
      unique case (cw.cond)
         COND_NONE:       cond_hit = 1'b0;
         COND_ALWAYS:     cond_hit = 1'b1;
         COND_NOT_LAST:   cond_hit = !flags.req_last;
         COND_I_GE_N:     cond_hit = flags.i_ge_n;
         COND_X_LT_GAP:   cond_hit = flags.x_lt_gap;
         COND_KEY_LESS:   cond_hit = flags.key_less;
         COND_GI_NONZERO: cond_hit = flags.gi_nonzero;
         COND_E_DONE:     cond_hit = flags.e_done;
         default:         cond_hit = 1'b0;
      endcase
   end

   always_comb begin
      ctrl.op = cw.op;
      ctrl.go = go;
   end

   always_comb begin
      if (!go) begin
         step_in = step_ff;
      end else if (cond_hit) begin
         step_in = cw.target;
      end else begin
         step_in = step_type'(step_ff + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

   `SSK_CHECK(a_compare_after_check, step_ff == ST_COMPARE, $past(step_ff) == ST_CHECK, "compare step not entered from check step")
   `SSK_CHECK(a_take_after_outer, step_ff == ST_TAKE, $past(step_ff) == ST_OUTER, "take step not entered from outer step")
   `SSK_CHECK_NEXT(a_last_starts_sort, (step_ff == ST_LOAD) && flags.req_valid && flags.req_last, step_ff == ST_GAP_INIT, "last word did not start the sort")

endmodule

// ===== rtl/ssk_datapath.sv =====
`timescale 1ns / 1ps
`include "shell_sort_keyed_records_top_macros.svh"

module ssk_datapath
   import ssk_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF,
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ssk_req_if.sink      req_if,
   ssk_rsp_if.source    rsp_if,
   input  dp_ctrl_type  ctrl,
   output dp_flags_type flags
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int AW     = $clog2(DEPTH);
   localparam int WORD_W = KEY_BITS + TAG_BITS;

   logic [WORD_W-1:0] mem [DEPTH];

   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 ovf_ff, ovf_in;
   logic [GAP_IDX_W-1:0] gi_ff, gi_in;
   logic [CNT_W-1:0]     gap_ff, gap_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     x_ff, x_in;
   logic [CNT_W-1:0]     e_ff, e_in;
   logic [KEY_BITS-1:0]  k_ff, k_in;
   logic [TAG_BITS-1:0]  t_ff, t_in;
   logic [WORD_W-1:0]    rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KEY_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic [KEY_BITS-1:0]  rd_key;
   logic [TAG_BITS-1:0]  rd_tag;
   logic [CNT_W-1:0]     x_minus_gap;
   logic                 mem_we;
   logic [CNT_W-1:0]     mem_wa;
   logic [WORD_W-1:0]    mem_wd;
   logic                 mem_re;
   logic [CNT_W-1:0]     mem_ra;

   assign rd_key      = rd_ff[WORD_W-1:TAG_BITS];
   assign rd_tag      = rd_ff[TAG_BITS-1:0];
   assign x_minus_gap = x_ff - gap_ff;

   assign req_if.ready = (ctrl.op == OP_LOAD);

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_key  = rsp_key_ff;
   assign rsp_if.out_tag  = rsp_tag_ff;
   assign rsp_if.out_last = rsp_last_ff;
   assign rsp_if.overflow = rsp_ovf_ff;

   always_comb begin
      flags.req_valid  = req_if.valid;
      flags.req_last   = req_if.last_item;
      flags.rsp_free   = !rsp_valid_ff || rsp_if.ready;
      flags.i_ge_n     = (i_ff >= n_ff);
      flags.x_lt_gap   = (x_ff < gap_ff);
      flags.key_less   = (k_ff < rd_key);
      flags.gi_nonzero = (gi_ff != '0);
      flags.e_done     = (e_ff >= n_ff);
   end

   // Record store port control. Reads are issued only for entries of the
   // current set, so the store needs no clearing.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = x_ff;
      mem_wd = rd_ff;
      mem_re = 1'b0;
      mem_ra = i_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            mem_we = ctrl.go && (n_ff < CNT_W'(DEPTH));
            mem_wa = n_ff;
            mem_wd = {req_if.sort_key, req_if.record_tag};
         end
         OP_MOVE: begin
            mem_we = flags.key_less;
         end
         OP_PLACE: begin
            mem_we = 1'b1;
            mem_wd = {k_ff, t_ff};
         end
         OP_RD_I: begin
            mem_re = !flags.i_ge_n;
         end
         OP_RD_X: begin
            mem_re = !flags.x_lt_gap;
            mem_ra = x_minus_gap;
         end
         OP_RD_E: begin
            mem_re = !flags.e_done;
            mem_ra = e_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa[AW-1:0]] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra[AW-1:0]];
      end
   end

   always_comb begin
      n_in         = n_ff;
      ovf_in       = ovf_ff;
      gi_in        = gi_ff;
      gap_in       = gap_ff;
      i_in         = i_ff;
      x_in         = x_ff;
      e_in         = e_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            if (ctrl.go) begin
               if (n_ff < CNT_W'(DEPTH)) begin
                  n_in = n_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         OP_GAP_INIT: begin
            gi_in  = first_gap_idx(int'(n_ff));
            gap_in = CNT_W'(gap_at(gi_in));
            i_in   = gap_in;
         end
         OP_TAKE_I: begin
            k_in = rd_key;
            t_in = rd_tag;
            x_in = i_ff;
         end
         OP_MOVE: begin
            if (flags.key_less) begin
               x_in = x_minus_gap;
            end
         end
         OP_PLACE: begin
            i_in = i_ff + CNT_W'(1);
         end
         OP_NEXT_GAP: begin
            if (flags.gi_nonzero) begin
               gi_in  = gi_ff - GAP_IDX_W'(1);
               gap_in = CNT_W'(gap_at(gi_in));
               i_in   = gap_in;
            end
         end
         OP_EMIT_INIT: begin
            e_in = '0;
         end
         OP_PUSH: begin
            if (ctrl.go) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = rd_key;
               rsp_tag_in   = rd_tag;
               rsp_last_in  = ((e_ff + CNT_W'(1)) == n_ff);
               rsp_ovf_in   = ovf_ff;
               e_in         = e_ff + CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            n_in   = '0;
            ovf_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_ff         <= n_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gi_ff       <= gi_in;
      gap_ff      <= gap_in;
      i_ff        <= i_in;
      x_ff        <= x_in;
      e_ff        <= e_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   `SSK_CHECK(a_sort_write_in_set, mem_we && ((ctrl.op == OP_MOVE) || (ctrl.op == OP_PLACE)), mem_wa < n_ff, "sort wrote outside the loaded set")
   `SSK_CHECK(a_read_in_set, mem_re, mem_ra < n_ff, "store read outside the loaded set")
   `SSK_CHECK(a_overflow_only_full, ovf_ff, n_ff == CNT_W'(DEPTH), "overflow flagged with room left")

endmodule
